// File: rtl/uud_pkg.sv
// ----------------------------------------------------------------------------
// uud_pkg
// Types, codes and character constants shared by the uudecode stream block.
// ----------------------------------------------------------------------------
package uud_pkg;

   // decoder phases
   localparam logic [2:0] PH_SEARCH = 3'd0;
   localparam logic [2:0] PH_SKIP   = 3'd1;
   localparam logic [2:0] PH_LINE   = 3'd2;
   localparam logic [2:0] PH_DATA   = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;

   // result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [7:0] CH_B  = 8'h62;
   localparam logic [7:0] CH_E  = 8'h65;
   localparam logic [7:0] CH_CR = 8'h0d;
   localparam logic [7:0] CH_LF = 8'h0a;

   localparam logic [2:0] HDR_LEN = 3'd6;
   localparam logic [2:0] END_LEN = 3'd5;
   localparam logic [1:0] GROUP_LAST = 2'd3;

   typedef struct packed {
      logic [2:0]  phase;
      logic [2:0]  header_match;
      logic [1:0]  group_pos;
      logic [17:0] group_bits;
      logic [5:0]  bytes_left;
      logic [2:0]  end_match;
      logic        saw_cr;
   } uud_state_type;

   localparam uud_state_type STATE_RESET = '{
      phase:        PH_SEARCH,
      header_match: 3'd0,
      group_pos:    2'd0,
      group_bits:   18'd0,
      bytes_left:   6'd0,
      end_match:    3'd0,
      saw_cr:       1'b0
   };

   // results caused by one character: leading bytes, then an optional tail
   typedef struct packed {
      logic [1:0]  nbytes;
      logic        tail_vld;
      logic [1:0]  tail_kind;
      logic [23:0] full;
   } uud_run_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } uud_slot_type;

   // "begin "
   function automatic logic [7:0] hdr_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0: ch = 8'h62;
         3'd1: ch = 8'h65;
         3'd2: ch = 8'h67;
         3'd3: ch = 8'h69;
         3'd4: ch = 8'h6e;
         3'd5: ch = 8'h20;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // "end" CR LF
   function automatic logic [7:0] end_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0: ch = 8'h65;
         3'd1: ch = 8'h6e;
         3'd2: ch = 8'h64;
         3'd3: ch = CH_CR;
         3'd4: ch = CH_LF;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      if (c >= 8'h41 && c <= 8'h5a) begin
         r = c + 8'd32;
      end else begin
         r = c;
      end
      return r;
   endfunction

endpackage

// File: rtl/uud_req_if.sv
// ----------------------------------------------------------------------------
// uud_req_if
// Request channel: one encoded character with its stream markers.
// ----------------------------------------------------------------------------
interface uud_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       last_char;
   logic       new_message;

   modport source (output valid, output in_char, output last_char,
                   output new_message, input ready);
   modport sink   (input valid, input in_char, input last_char,
                   input new_message, output ready);
endinterface

// File: rtl/uud_rsp_if.sv
// ----------------------------------------------------------------------------
// uud_rsp_if
// Response channel: one decoded byte or a finish / error marker.
// ----------------------------------------------------------------------------
interface uud_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   logic       last_of_run;

   modport source (output valid, output kind, output data_byte,
                   output last_of_run, input ready);
   modport sink   (input valid, input kind, input data_byte,
                   input last_of_run, output ready);
endinterface

// File: rtl/uud_step.sv
// ----------------------------------------------------------------------------
// uud_step
// Next-state and result logic for one character of uuencoded text.
// ----------------------------------------------------------------------------
module uud_step (
   input  uud_pkg::uud_state_type state_cur,
   input  logic [7:0]             in_char,
   input  logic                   last_char,
   input  logic                   new_message,
   output uud_pkg::uud_state_type state_nxt,
   output uud_pkg::uud_run_type   run
);
   import uud_pkg::*;

   always_comb begin
      uud_state_type s;
      logic [5:0]    v;
      logic [7:0]    fc;
      logic [2:0]    em;
      logic [1:0]    k;
      logic [5:0]    bl;

      s  = new_message ? STATE_RESET : state_cur;
      v  = 6'(in_char[5:0] - 6'd32);
      fc = fold_case(in_char);
      em = s.end_match;
      k  = 2'd0;
      bl = s.bytes_left;
      run = '0;
      run.full = {s.group_bits, v};

      unique case (s.phase)
         PH_SEARCH: begin
            if (s.header_match < HDR_LEN && in_char == hdr_char(s.header_match)) begin
               if (s.header_match == HDR_LEN - 3'd1) begin
                  s.header_match = 3'd0;
                  s.saw_cr = 1'b0;
                  s.phase = PH_SKIP;
               end else begin
                  s.header_match = s.header_match + 3'd1;
               end
            end else begin
               s.header_match = (in_char == CH_B) ? 3'd1 : 3'd0;
            end
         end
         PH_SKIP: begin
            if (s.saw_cr && in_char == CH_LF) begin
               s.saw_cr = 1'b0;
               s.phase = PH_LINE;
            end else begin
               s.saw_cr = (in_char == CH_CR);
            end
         end
         PH_LINE: begin
            if (v == 6'd0) begin
               run.tail_vld = 1'b1;
               run.tail_kind = KIND_DONE;
               s.phase = PH_DONE;
            end else begin
               s.bytes_left = v;
               s.group_pos = 2'd0;
               s.group_bits = 18'd0;
               s.end_match = (fc == CH_E) ? 3'd1 : 3'd0;
               s.phase = PH_DATA;
            end
         end
         PH_DATA: begin
            // "end" line compare runs alongside normal data decode
            if (em != 3'd0 && em < END_LEN) begin
               em = (fc == end_char(em)) ? em + 3'd1 : 3'd0;
            end
            s.end_match = em;
            if (s.group_pos != GROUP_LAST) begin
               s.group_bits = {s.group_bits[11:0], v};
               s.group_pos = s.group_pos + 2'd1;
            end else begin
               s.group_pos = 2'd0;
               s.group_bits = 18'd0;
               s.end_match = 3'd0;
               if (em == END_LEN) begin
                  run.tail_vld = 1'b1;
                  run.tail_kind = KIND_DONE;
                  s.phase = PH_DONE;
               end else begin
                  k = (s.bytes_left < 6'd3) ? s.bytes_left[1:0] : 2'd3;
                  run.nbytes = k;
                  bl = s.bytes_left - {4'd0, k};
                  s.bytes_left = bl;
                  if (bl == 6'd0) begin
                     s.saw_cr = 1'b0;
                     s.phase = PH_SKIP;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      if (last_char) begin
         if (s.phase != PH_DONE) begin
            run.tail_vld = 1'b1;
            run.tail_kind = KIND_ERROR;
         end
         s = STATE_RESET;
      end

      state_nxt = s;
   end

endmodule

// File: rtl/uudecode_stream_unit.sv
// ----------------------------------------------------------------------------
// uudecode_stream_unit
// Streaming uudecoder: one encoded character in, decoded bytes and
// finish / error markers out.
//
// req_ch carries one character per request, with last_char marking the end
// of the text and new_message restarting the header search at this
// character. rsp_ch carries the results one per transfer, up to four per
// request: a decoded byte, a clean finish marker, or an end-of-text error.
// last_of_run flags the final result caused by one character.
//
// A character is decoded in the cycle it is accepted; its results are
// loaded into a four-entry result queue and the first one is presented the
// next cycle. While the receiver keeps up, characters that cause no result
// or a single result are taken at one per cycle. A character causing more
// than one result holds req_ch back while the queue drains, since a
// new run is loaded only as the last entry of the previous one leaves.
//
// Reset (synchronous) returns the decoder to header search and empties the
// queue. When the receiver stalls, the queue holds and req_ch backs up as
// soon as any result is waiting.
// ----------------------------------------------------------------------------
module uudecode_stream_unit (
   input logic      clock,
   input logic      reset,
   uud_req_if.sink   req_ch,
   uud_rsp_if.source rsp_ch
);
   import uud_pkg::*;

   localparam int NSLOT = 4;

   uud_state_type state_ff, state_in, state_nxt;
   uud_run_type   run;
   uud_slot_type  slot_ff [NSLOT];
   uud_slot_type  slot_in [NSLOT];
   uud_slot_type  load    [NSLOT];
   logic [7:0]    run_byte [NSLOT];
   logic [NSLOT-1:0] slot_vld_ff, slot_vld_in, load_vld;
   logic req_take, rsp_take;

   uud_step u_step (
      .state_cur   (state_ff),
      .in_char     (req_ch.in_char),
      .last_char   (req_ch.last_char),
      .new_message (req_ch.new_message),
      .state_nxt   (state_nxt),
      .run         (run)
   );

   // a new run may enter when the queue is empty or as the last queued result leaves
   assign req_ch.ready = !slot_vld_ff[0] || (!slot_vld_ff[1] && rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;
   assign rsp_take = rsp_ch.valid && rsp_ch.ready;

   assign rsp_ch.valid       = slot_vld_ff[0];
   assign rsp_ch.kind        = slot_ff[0].kind;
   assign rsp_ch.data_byte   = slot_ff[0].data_byte;
   assign rsp_ch.last_of_run = !slot_vld_ff[1];

   assign state_in = req_take ? state_nxt : state_ff;

   always_comb begin
      run_byte[0] = run.full[23:16];
      run_byte[1] = run.full[15:8];
      run_byte[2] = run.full[7:0];
      run_byte[3] = 8'd0;
      for (int j = 0; j < NSLOT; j++) begin
         if ({1'b0, run.nbytes} > 3'(j)) begin
            load_vld[j] = 1'b1;
            load[j].kind = KIND_BYTE;
            load[j].data_byte = run_byte[j];
         end else begin
            load_vld[j] = run.tail_vld && ({1'b0, run.nbytes} == 3'(j));
            load[j].kind = run.tail_kind;
            load[j].data_byte = 8'd0;
         end
      end
   end

   always_comb begin
      priority if (req_take) begin
         slot_vld_in = load_vld;
         for (int j = 0; j < NSLOT; j++) begin
            slot_in[j] = load[j];
         end
      end else if (rsp_take) begin
         slot_vld_in = {1'b0, slot_vld_ff[NSLOT-1:1]};
         for (int j = 0; j < NSLOT - 1; j++) begin
            slot_in[j] = slot_ff[j+1];
         end
         slot_in[NSLOT-1] = slot_ff[NSLOT-1];
      end else begin
         slot_vld_in = slot_vld_ff;
         for (int j = 0; j < NSLOT; j++) begin
            slot_in[j] = slot_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= STATE_RESET;
         slot_vld_ff <= '0;
      end else begin
         state_ff    <= state_in;
         slot_vld_ff <= slot_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < NSLOT; j++) begin
         slot_ff[j] <= slot_in[j];
      end
   end

`ifndef SYNTH
   // queued results stay packed toward the head
   a_slots_packed: assert property (@(posedge clock) disable iff (reset)
      (slot_vld_ff[0] || !slot_vld_ff[1]) && (slot_vld_ff[1] || !slot_vld_ff[2])
      && (slot_vld_ff[2] || !slot_vld_ff[3]))
      else $error("result queue has a gap");

   // finish and error markers always close their run
   a_tail_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.kind != KIND_BYTE |-> rsp_ch.last_of_run
      && rsp_ch.data_byte == 8'd0)
      else $error("marker result not last or carries data");

   // end of text returns the decoder to header search
   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      req_take && req_ch.last_char |=> state_ff.phase == PH_SEARCH
      && state_ff.header_match == 3'd0)
      else $error("decoder not reset after last character");

   // input stalls only behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> rsp_ch.valid && !rsp_ch.last_of_run || rsp_ch.valid && !rsp_ch.ready)
      else $error("request stalled with no pending result");
`endif

endmodule

// File: tb/uud_stream_checker.sv
// ----------------------------------------------------------------------------
// uud_stream_checker
// Watches both channels of the uudecode stream unit. It decodes each
// accepted character with its own copy of the decoder state, queues the
// results that character should cause, and compares every accepted
// response against the oldest queued one.
// ----------------------------------------------------------------------------
module uud_stream_checker (
   input  logic clock,
   input  logic reset,
   uud_req_if   req_ch,
   uud_rsp_if   rsp_ch,
   output int   fail_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import uud_pkg::*;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       last_of_run;
   } decoded_type;

   localparam logic [47:0] HEADER_TEXT = "begin ";
   localparam logic [39:0] END_TEXT    = {"end", CH_CR, CH_LF};

   // decoder state
   logic [2:0]  phase;
   logic [2:0]  hdr_pos;
   logic [1:0]  grp_pos;
   logic [17:0] grp_bits;
   logic [5:0]  bytes_due;
   logic [2:0]  end_pos;
   logic        cr_seen;

   decoded_type expected_q[$];
   int          errors = 0;

   task automatic clear_decoder();
      phase     = PH_SEARCH;
      hdr_pos   = 3'd0;
      grp_pos   = 2'd0;
      grp_bits  = 18'd0;
      bytes_due = 6'd0;
      end_pos   = 3'd0;
      cr_seen   = 1'b0;
   endtask

   task automatic decode_char(input logic [7:0] ch, input logic last, input logic fresh);
      decoded_type run [4];
      int          n;
      logic [5:0]  sextet;
      logic [7:0]  folded;
      logic [23:0] word;
      logic [5:0]  take;
      n      = 0;
      sextet = 6'(ch - 8'd32);
      folded = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
      if (fresh) begin
         clear_decoder();
      end
      case (phase)
         PH_SEARCH: begin
            if (hdr_pos < HDR_LEN && ch == HEADER_TEXT[47 - 8 * int'(hdr_pos) -: 8]) begin
               hdr_pos = hdr_pos + 3'd1;
               if (hdr_pos == HDR_LEN) begin
                  hdr_pos = 3'd0;
                  cr_seen = 1'b0;
                  phase   = PH_SKIP;
               end
            end else begin
               // a 'b' can open a new match
               hdr_pos = (ch == CH_B) ? 3'd1 : 3'd0;
            end
         end
         PH_SKIP: begin
            if (cr_seen && ch == CH_LF) begin
               cr_seen = 1'b0;
               phase   = PH_LINE;
            end else begin
               cr_seen = (ch == CH_CR);
            end
         end
         PH_LINE: begin
            if (sextet == 6'd0) begin
               run[n] = '{KIND_DONE, 8'h00, 1'b0};
               n++;
               phase = PH_DONE;
            end else begin
               bytes_due = sextet;
               grp_pos   = 2'd0;
               grp_bits  = 18'd0;
               end_pos   = (folded == CH_E) ? 3'd1 : 3'd0;
               phase     = PH_DATA;
            end
         end
         PH_DATA: begin
            if (end_pos != 3'd0 && end_pos < END_LEN) begin
               if (folded == END_TEXT[39 - 8 * int'(end_pos) -: 8]) begin
                  end_pos = end_pos + 3'd1;
               end else begin
                  end_pos = 3'd0;
               end
            end
            if (grp_pos < GROUP_LAST) begin
               grp_bits = {grp_bits[11:0], sextet};
               grp_pos  = grp_pos + 2'd1;
            end else begin
               word     = {grp_bits, sextet};
               grp_pos  = 2'd0;
               grp_bits = 18'd0;
               if (end_pos == END_LEN) begin
                  // the end line swallows its own group
                  end_pos = 3'd0;
                  run[n]  = '{KIND_DONE, 8'h00, 1'b0};
                  n++;
                  phase = PH_DONE;
               end else begin
                  end_pos = 3'd0;
                  take    = (bytes_due < 6'd3) ? bytes_due : 6'd3;
                  if (take >= 6'd1) begin
                     run[n] = '{KIND_BYTE, word[23:16], 1'b0};
                     n++;
                  end
                  if (take >= 6'd2) begin
                     run[n] = '{KIND_BYTE, word[15:8], 1'b0};
                     n++;
                  end
                  if (take >= 6'd3) begin
                     run[n] = '{KIND_BYTE, word[7:0], 1'b0};
                     n++;
                  end
                  bytes_due = bytes_due - take;
                  if (bytes_due == 6'd0) begin
                     cr_seen = 1'b0;
                     phase   = PH_SKIP;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      if (last) begin
         if (phase != PH_DONE) begin
            run[n] = '{KIND_ERROR, 8'h00, 1'b0};
            n++;
         end
         clear_decoder();
      end
      if (n > 0) begin
         run[n - 1].last_of_run = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         expected_q.push_back(run[i]);
      end
   endtask

   always @(posedge clock) begin
      decoded_type got;
      decoded_type want;
      if (reset) begin
         clear_decoder();
         expected_q.delete();
      end else begin
         // responses first: a request never answers in its own cycle
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.kind, rsp_ch.data_byte, rsp_ch.last_of_run};
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result: kind=%0d byte=%02h last=%0b",
                        $time, got.kind, got.data_byte, got.last_of_run);
               errors++;
            end else begin
               want = expected_q.pop_front();
               if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                   got.last_of_run !== want.last_of_run) begin
                  $display("%0t: mismatch: expected %0d/%02h/%0b, got %0d/%02h/%0b",
                           $time, want.kind, want.data_byte, want.last_of_run,
                           got.kind, got.data_byte, got.last_of_run);
                  errors++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            decode_char(req_ch.in_char, req_ch.last_char, req_ch.new_message);
         end
      end
      fail_count    <= errors;
      pending_count <= expected_q.size();
   end

endmodule

// File: tb/tb_uudecode_stream_unit.sv
// ----------------------------------------------------------------------------
// tb_uudecode_stream_unit
// Feeds the uudecode stream unit a directed set of texts and then random
// uuencoded messages (noise, false header starts, short and long lines, end
// lines in mixed case, texts cut off early), with bursty requests and a
// stalling receiver. Checking is done by the checker beside the block.
// ----------------------------------------------------------------------------
module tb_uudecode_stream_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import uud_pkg::*;

   localparam int RANDOM_CHARS = 270;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_START   = 250;
   localparam int HOLD_CYCLES  = 150;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       fresh;
   } char_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   idle_cycles = 0;

   char_item_type stream_q[$];

   uud_req_if req_ch ();
   uud_rsp_if rsp_ch ();

   uudecode_stream_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   uud_stream_checker decode_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5ns clock = ~clock;

   task automatic add_char(input logic [7:0] ch);
      stream_q.push_back('{ch, 1'b0, 1'b0});
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_char(s[i]);
      end
   endtask

   task automatic mark_char(input int idx, input logic last, input logic fresh);
      char_item_type item;
      item       = stream_q[idx];
      item.last  = item.last | last;
      item.fresh = item.fresh | fresh;
      stream_q[idx] = item;
   endtask

   // sometimes a doubled CR before the LF
   task automatic add_line_end();
      if ($urandom_range(0, 7) == 0) begin
         add_char(CH_CR);
      end
      add_char(CH_CR);
      add_char(CH_LF);
   endtask

   function automatic logic [7:0] encoded_char();
      logic [5:0] sextet;
      if ($urandom_range(0, 19) == 0) begin
         return 8'($urandom_range(0, 255));
      end
      sextet = 6'($urandom_range(0, 63));
      if (sextet == 6'd0) begin
         return $urandom_range(0, 1) ? 8'h60 : 8'h20;
      end
      return 8'(sextet + 32);
   endfunction

   task automatic add_message();
      int start;
      int len;
      int nchars;
      int pick;
      start = stream_q.size();
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 4)) add_char(8'($urandom_range(0, 255)));
      end
      case ($urandom_range(0, 5))
         0: add_text("beg");
         1: add_text("b");
         2: add_text("Begin ");
         default: begin
         end
      endcase
      add_text("begin ");
      repeat ($urandom_range(0, 6)) add_char(8'($urandom_range(8'h21, 8'h7e)));
      if ($urandom_range(0, 4) == 0) begin
         add_char(CH_CR);
         add_char("x");
      end
      add_line_end();
      repeat ($urandom_range(0, 3)) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 7);
         add_char(($urandom_range(0, 5) == 0) ? 8'(len + 96) : 8'(len + 32));
         nchars = (len + 2) / 3 * 4;
         if ($urandom_range(0, 9) == 0) begin
            nchars = $urandom_range(0, nchars);
         end
         repeat (nchars) add_char(encoded_char());
         add_line_end();
      end
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         add_char($urandom_range(0, 1) ? 8'h60 : 8'h20);
         add_line_end();
      end else if (pick < 7) begin
         add_char($urandom_range(0, 1) ? "E" : "e");
         add_char($urandom_range(0, 1) ? "N" : "n");
         add_char($urandom_range(0, 1) ? "D" : "d");
         add_line_end();
      end else if (pick == 7) begin
         add_text("en");
         add_char(8'($urandom_range(0, 255)));
         add_line_end();
      end
      if ($urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(1, 5)) add_char(encoded_char());
      end
      if ($urandom_range(0, 1) == 0) begin
         mark_char(start, 1'b0, 1'b1);
      end
      if ($urandom_range(0, 3) != 0) begin
         mark_char(stream_q.size() - 1, 1'b1, 1'b0);
      end
   endtask

   // receiver: runs of full rate, light and heavy stalls, one long hold-off
   initial begin
      int  mode_left;
      int  mode;
      int  cycle;
      bit  held;
      mode_left = 0;
      mode      = 0;
      cycle     = 0;
      held      = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && cycle >= HOLD_START) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            cycle += HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(5, 60);
         end
         case (mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 2) != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         endcase
         mode_left--;
         cycle++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int directed_count;
      int burst_left;
      int gap;
      req_ch.valid       <= 1'b0;
      req_ch.in_char     <= 8'h00;
      req_ch.last_char   <= 1'b0;
      req_ch.new_message <= 1'b0;

      // restart flag on a null character, header with a false 'b' start
      // and a doubled CR, then a full group cut off by the end of text
      add_char(8'h00);
      mark_char(0, 1'b0, 1'b1);
      add_text("bebegin ");
      add_char(CH_CR);
      add_char(CH_CR);
      add_char(CH_LF);
      add_text("#0V%T");
      mark_char(stream_q.size() - 1, 1'b1, 1'b0);
      // restarted text closed by a zero length line, then ignored tail
      add_text("begin ");
      mark_char(stream_q.size() - 6, 1'b0, 1'b1);
      add_char(CH_CR);
      add_char(CH_LF);
      add_char(8'h20);
      add_char(8'hff);
      mark_char(stream_q.size() - 1, 1'b1, 1'b0);
      directed_count = stream_q.size();

      while (stream_q.size() < directed_count + RANDOM_CHARS) begin
         add_message();
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      burst_left = 0;
      foreach (stream_q[i]) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         req_ch.valid       <= 1'b1;
         req_ch.in_char     <= stream_q[i].ch;
         req_ch.last_char   <= stream_q[i].last;
         req_ch.new_message <= stream_q[i].fresh;
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
         burst_left--;
      end
      req_ch.valid <= 1'b0;

      // wait for the checker to register the final request
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
